FILE: hw/rtl/fuzzy_membership_per_pixel_macros.svh
// Assertion macros for the fuzzy membership block checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef FUZZY_MEMBERSHIP_PER_PIXEL_MACROS_SVH
`define FUZZY_MEMBERSHIP_PER_PIXEL_MACROS_SVH

// same-cycle implication
`define FMP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fmp assertion failed");

// next-cycle implication
`define FMP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fmp assertion failed");

`endif

FILE: hw/rtl/fmp_pkg.sv
// Shared constants, types and register codes of the fuzzy membership block.
// No dependencies.
package fmp_pkg;

  localparam int unsigned MaxClasses = 4;
  localparam int unsigned DataW      = 16;
  localparam int unsigned MagW       = 32;
  localparam int unsigned SqW        = 64;
  localparam int unsigned PairW      = 128;
  localparam int unsigned PartW      = 160;
  localparam int unsigned ProdW      = 192;
  localparam int unsigned HalfSumW   = 193;
  localparam int unsigned SumW       = 194;
  localparam int unsigned RemW       = 195;
  localparam int unsigned QuotW      = 17;
  localparam int unsigned DivSteps   = 17;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned AddrW      = 5;

  localparam logic [DataW-1:0] GainOne   = 16'd16384;
  localparam logic [DataW-1:0] MemberMax = 16'hFFFF;
  localparam logic [2:0]       NumReset  = 3'd3;

  typedef enum logic [2:0] {
    RegNumClasses = 3'd0,
    RegCenter0    = 3'd1,
    RegCenter1    = 3'd2,
    RegCenter2    = 3'd3,
    RegCenter3    = 3'd4
  } fmp_reg_e;

  typedef struct packed {
    logic                  bg;
    logic                  gone;
    logic [MaxClasses-1:0] act;
    logic [MaxClasses-1:0] zm;
  } fmp_ctl_t;

  typedef struct packed {
    fmp_ctl_t                        ctl;
    logic [MaxClasses-1:0][MagW-1:0] mag;
  } fmp_item_t;

endpackage

FILE: hw/rtl/fuzzy_membership_per_pixel.sv
// Fuzzy c-means membership (exponent 2) per pixel, top level.
// Depends on fmp_pkg, fmp_front, fmp_queue, fmp_prod, fmp_div.
//
// Input stream s_*: s_tdata = {gain, intensity}, one pixel per transaction.
// Output stream m_*: m_tdata = {member_3, member_2, member_1, member_0},
// m_tuser = is_background. One result per pixel, in order.
// APB port: num_classes at 0x00, center_0..center_3 at 0x04..0x10;
// write only while the block is idle.
// Throughput: one pixel per cycle while the output is not stalled. A pixel
// passes the queue, the eight product/sum stages, the seventeen-stage
// restoring divider (one quotient bit per stage) and the result register.
// The front end writes into a two-entry queue; the back end pipeline holds
// while m_tvalid is high and m_tready is low, and the queue then fills and
// drops s_tready. Reset empties queue and pipeline, sets num_classes to 3
// and all centers to 0.
module fuzzy_membership_per_pixel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // intensity[15:0], gain[31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // member_0, member_1, member_2, member_3
  output logic [0:0]  m_tuser,   // is_background
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [fmp_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fmp_pkg::*;

  logic [2:0]                       num_q;
  logic [MaxClasses-1:0][DataW-1:0] center_q;
  fmp_reg_e                         ridx;
  fmp_item_t                        f_item, q_item;
  logic                             q_valid, adv, p_valid, d_valid, d_bg;
  fmp_ctl_t                         p_ctl;
  logic [MaxClasses-1:0][ProdW-1:0] p_prod;
  logic [SumW-1:0]                  p_sum;
  logic [MaxClasses-1:0][DataW-1:0] d_mem;

  assign pready = 1'b1;
  assign ridx   = fmp_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q    <= NumReset;
      center_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        RegNumClasses: num_q       <= pwdata[2:0];
        RegCenter0:    center_q[0] <= pwdata[15:0];
        RegCenter1:    center_q[1] <= pwdata[15:0];
        RegCenter2:    center_q[2] <= pwdata[15:0];
        RegCenter3:    center_q[3] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      RegNumClasses: prdata = {29'b0, num_q};
      RegCenter0:    prdata = {16'b0, center_q[0]};
      RegCenter1:    prdata = {16'b0, center_q[1]};
      RegCenter2:    prdata = {16'b0, center_q[2]};
      RegCenter3:    prdata = {16'b0, center_q[3]};
      default:       prdata = '0;
    endcase
  end

  assign adv = !m_tvalid || m_tready;

  fmp_front u_front (
    .intensity_i  (s_tdata[15:0]),
    .gain_i       (s_tdata[31:16]),
    .num_classes_i(num_q),
    .center_i     (center_q),
    .item_o       (f_item)
  );

  fmp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s_tvalid),
    .data_i (f_item),
    .ready_o(s_tready),
    .pop_i  (adv),
    .data_o (q_item),
    .valid_o(q_valid)
  );

  fmp_prod u_prod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(q_valid),
    .item_i (q_item),
    .valid_o(p_valid),
    .ctl_o  (p_ctl),
    .prod_o (p_prod),
    .sum_o  (p_sum)
  );

  fmp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (p_valid),
    .ctl_i   (p_ctl),
    .prod_i  (p_prod),
    .sum_i   (p_sum),
    .valid_o (d_valid),
    .member_o(d_mem),
    .bg_o    (d_bg)
  );

  assign m_tvalid = d_valid;
  assign m_tdata  = {d_mem[3], d_mem[2], d_mem[1], d_mem[0]};
  assign m_tuser  = d_bg;

endmodule

FILE: hw/rtl/fmp_front.sv
// Front end: classifies a pixel and computes class distance magnitudes.
// Depends on fmp_pkg.
module fmp_front (
  input  logic [fmp_pkg::DataW-1:0]                     intensity_i,
  input  logic [fmp_pkg::DataW-1:0]                     gain_i,
  input  logic [2:0]                                    num_classes_i,
  input  logic [fmp_pkg::MaxClasses-1:0][fmp_pkg::DataW-1:0] center_i,
  output fmp_pkg::fmp_item_t                            item_o
);
  import fmp_pkg::*;

  logic [2:0]      n;
  logic [MagW-1:0] a;
  logic [MagW-1:0] b [MaxClasses];

  always_comb begin
    n = num_classes_i;
    if (n == 3'd0) n = 3'd1;
    if (n > 3'(MaxClasses)) n = 3'(MaxClasses);
    a = {2'b00, intensity_i, 14'b0};
    item_o.ctl.bg   = intensity_i < center_i[0];
    item_o.ctl.gone = gain_i == GainOne;
    for (int k = 0; k < MaxClasses; k++) begin
      b[k] = 32'(center_i[k]) * 32'(gain_i);
      item_o.mag[k]    = (a >= b[k]) ? a - b[k] : b[k] - a;
      item_o.ctl.act[k] = 3'(k) < n;
      item_o.ctl.zm[k]  = item_o.ctl.act[k] && (item_o.mag[k] == '0);
    end
  end

endmodule

FILE: hw/rtl/fmp_queue.sv
// Two-entry queue between front end and back end.
// Depends on fmp_pkg.
module fmp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fmp_pkg::fmp_item_t data_i,
  output logic               ready_o,
  input  logic               pop_i,
  output fmp_pkg::fmp_item_t data_o,
  output logic               valid_o
);
  import fmp_pkg::*;

  fmp_item_t  mem_q [QueueDepth];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign valid_o = cnt_q != 2'd0;
  assign ready_o = (cnt_q != 2'(QueueDepth)) || pop_i;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

endmodule

FILE: hw/rtl/fmp_prod.sv
// Back end products: squared distances, cross products and their sum.
// Depends on fmp_pkg.
module fmp_prod (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        adv_i,
  input  logic                                        valid_i,
  input  fmp_pkg::fmp_item_t                          item_i,
  output logic                                        valid_o,
  output fmp_pkg::fmp_ctl_t                           ctl_o,
  output logic [fmp_pkg::MaxClasses-1:0][fmp_pkg::ProdW-1:0] prod_o,
  output logic [fmp_pkg::SumW-1:0]                    sum_o
);
  import fmp_pkg::*;

  logic [7:0]  v_q;
  fmp_ctl_t    c_q [8];
  logic [SqW-1:0]      sq1_q [MaxClasses], sq2_q [MaxClasses], sq3_q [MaxClasses];
  logic [SqW-1:0]      pa_q [2][4];
  logic [PairW-1:0]    t_q [2];
  logic [SqW-1:0]      pk_q [MaxClasses][2][4];
  logic [PartW-1:0]    u_q [MaxClasses][2];
  logic [ProdW-1:0]    p6_q [MaxClasses], p7_q [MaxClasses], p8_q [MaxClasses];
  logic [HalfSumW-1:0] h_q [2];
  logic [SumW-1:0]     s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_q[0] <= item_i.ctl;
      for (int s = 1; s < 8; s++) c_q[s] <= c_q[s-1];
      for (int k = 0; k < MaxClasses; k++) begin
        sq1_q[k] <= item_i.ctl.act[k] ? 64'(item_i.mag[k]) * 64'(item_i.mag[k]) : 64'd1;
        sq2_q[k] <= sq1_q[k];
        sq3_q[k] <= sq2_q[k];
      end
      for (int h = 0; h < 2; h++) begin
        for (int m = 0; m < 4; m++) begin
          pa_q[h][m] <= 64'(sq1_q[2*h][32*(m/2)+:32]) * 64'(sq1_q[2*h+1][32*(m%2)+:32]);
        end
        t_q[h] <= 128'(pa_q[h][0]) + (128'(pa_q[h][1]) << 32)
                + (128'(pa_q[h][2]) << 32) + (128'(pa_q[h][3]) << 64);
      end
      for (int k = 0; k < MaxClasses; k++) begin
        for (int i = 0; i < 2; i++) begin
          for (int j = 0; j < 4; j++) begin
            pk_q[k][i][j] <= 64'(sq3_q[k^1][32*i+:32]) * 64'(t_q[(k < 2) ? 1 : 0][32*j+:32]);
          end
          u_q[k][i] <= 160'(pk_q[k][i][0]) + (160'(pk_q[k][i][1]) << 32)
                     + (160'(pk_q[k][i][2]) << 64) + (160'(pk_q[k][i][3]) << 96);
        end
        p6_q[k] <= c_q[4].act[k] ? 192'(u_q[k][0]) + (192'(u_q[k][1]) << 32) : '0;
        p7_q[k] <= p6_q[k];
        p8_q[k] <= p7_q[k];
      end
      h_q[0] <= 193'(p6_q[0]) + 193'(p6_q[1]);
      h_q[1] <= 193'(p6_q[2]) + 193'(p6_q[3]);
      s_q    <= 194'(h_q[0]) + 194'(h_q[1]);
    end
  end

  assign valid_o = v_q[7];
  assign ctl_o   = c_q[7];
  assign sum_o   = s_q;
  always_comb begin
    for (int k = 0; k < MaxClasses; k++) prod_o[k] = p8_q[k];
  end

endmodule

FILE: hw/rtl/fmp_div.sv
// Back end division: restoring divider pipeline, one quotient bit per stage,
// and the result register. Depends on fmp_pkg.
module fmp_div (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        adv_i,
  input  logic                                        valid_i,
  input  fmp_pkg::fmp_ctl_t                           ctl_i,
  input  logic [fmp_pkg::MaxClasses-1:0][fmp_pkg::ProdW-1:0] prod_i,
  input  logic [fmp_pkg::SumW-1:0]                    sum_i,
  output logic                                        valid_o,
  output logic [fmp_pkg::MaxClasses-1:0][fmp_pkg::DataW-1:0] member_o,
  output logic                                        bg_o
);
  import fmp_pkg::*;

  logic [DivSteps-1:0] v_q;
  fmp_ctl_t            c_q [DivSteps];
  logic [SumW-1:0]     s_q [DivSteps];
  logic [RemW-1:0]     r_q [DivSteps][MaxClasses];
  logic [QuotW-1:0]    q_q [DivSteps][MaxClasses];
  logic [RemW-1:0]     ri  [DivSteps][MaxClasses];
  logic                out_v_q;
  logic [MaxClasses-1:0][DataW-1:0] mem_q, mem_d;
  logic                bg_q;

  always_comb begin
    for (int j = 0; j < DivSteps; j++) begin
      for (int k = 0; k < MaxClasses; k++) begin
        if (j == 0) ri[j][k] = RemW'(prod_i[k]);
        else        ri[j][k] = {r_q[(j == 0) ? 0 : j-1][k][RemW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int j = 0; j < DivSteps; j++) begin
        c_q[j] <= (j == 0) ? ctl_i : c_q[(j == 0) ? 0 : j-1];
        s_q[j] <= (j == 0) ? sum_i : s_q[(j == 0) ? 0 : j-1];
        for (int k = 0; k < MaxClasses; k++) begin
          if (ri[j][k] >= RemW'((j == 0) ? sum_i : s_q[(j == 0) ? 0 : j-1])) begin
            r_q[j][k] <= ri[j][k] - RemW'((j == 0) ? sum_i : s_q[(j == 0) ? 0 : j-1]);
            q_q[j][k] <= (j == 0) ? QuotW'(1)
                       : {q_q[(j == 0) ? 0 : j-1][k][QuotW-2:0], 1'b1};
          end else begin
            r_q[j][k] <= ri[j][k];
            q_q[j][k] <= (j == 0) ? QuotW'(0)
                       : {q_q[(j == 0) ? 0 : j-1][k][QuotW-2:0], 1'b0};
          end
        end
      end
      mem_q <= mem_d;
      bg_q  <= c_q[DivSteps-1].bg;
    end
  end

  always_comb begin
    for (int k = 0; k < MaxClasses; k++) begin
      if (c_q[DivSteps-1].bg || !c_q[DivSteps-1].act[k]) begin
        mem_d[k] = '0;
      end else if (c_q[DivSteps-1].zm != '0) begin
        mem_d[k] = (c_q[DivSteps-1].zm[k] && c_q[DivSteps-1].gone) ? MemberMax : '0;
      end else if (q_q[DivSteps-1][k][QuotW-1]) begin
        mem_d[k] = MemberMax;
      end else begin
        mem_d[k] = q_q[DivSteps-1][k][DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (adv_i) begin
      v_q     <= {v_q[DivSteps-2:0], valid_i};
      out_v_q <= v_q[DivSteps-1];
    end
  end

  assign valid_o  = out_v_q;
  assign member_o = mem_q;
  assign bg_o     = bg_q;

endmodule

FILE: hw/rtl/fmp_checker.sv
// Port-level checker for the fuzzy membership block, bound to the top level.
// Depends on fuzzy_membership_per_pixel_macros.svh.
`include "fuzzy_membership_per_pixel_macros.svh"

module fmp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        psel,
  input logic        pready
);

  `FMP_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `FMP_ASSERT_IMP(a_bg_zero, m_tvalid && m_tuser[0], m_tdata == 64'd0)
  `FMP_ASSERT_IMP(a_pready, psel, pready)
  `FMP_ASSERT_IMP(a_in_stall, !s_tready, m_tvalid && !m_tready)

endmodule

bind fuzzy_membership_per_pixel fmp_checker u_fmp_checker (.*);
